/* sv/lbpc_pkg.sv */
// Shared types, constants and the ladder decode function of the button press classifier.
package lbpc_pkg;

    localparam int SAMPLES_PER_POLL = 4;
    localparam int SAMPLE_W = 12;
    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_POLL + 1);
    localparam int TICK_W = 32;
    localparam int DELTA_W = 16;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 8'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd500;

    localparam logic [SAMPLE_W-1:0] LVL_600 = 12'd600;
    localparam logic [SAMPLE_W-1:0] LVL_950 = 12'd950;
    localparam logic [SAMPLE_W-1:0] LVL_1540 = 12'd1540;
    localparam logic [SAMPLE_W-1:0] LVL_2600 = 12'd2600;
    localparam logic [SAMPLE_W-1:0] LVL_1700 = 12'd1700;
    localparam logic [SAMPLE_W-1:0] LVL_1500 = 12'd1500;
    localparam logic [SAMPLE_W-1:0] LVL_988 = 12'd988;

    typedef enum logic [1:0] {
        LAD_NONE = 2'd0,
        LAD_SW1  = 2'd1,
        LAD_SW2  = 2'd2,
        LAD_BOTH = 2'd3
    } ladder_t;

    typedef enum logic [2:0] {
        KIND_ENC        = 3'd0,
        KIND_BACK_SHORT = 3'd1,
        KIND_BACK_LONG  = 3'd2,
        KIND_OK_SHORT   = 3'd3,
        KIND_OK_LONG    = 3'd4
    } kind_t;

    typedef struct packed {
        logic                      enc_valid;
        logic signed [DELTA_W-1:0] delta;
        logic                      btn_valid;
        kind_t                     btn_kind;
    } poll_events_t;

    function automatic ladder_t decode_ladder(input ladder_t held, input logic [SAMPLE_W-1:0] level);
        ladder_t res;
        res = held;
        case (held)
            LAD_NONE:
            begin
                if (level < LVL_600) res = LAD_SW1;
                else if (level < LVL_950) res = LAD_BOTH;
                else if (level < LVL_1540) res = LAD_SW2;
                else if (level < LVL_2600) res = LAD_SW1;
                else res = LAD_NONE;
            end
            LAD_SW1:
            begin
                if (level > LVL_2600) res = LAD_NONE;
                else if (level < LVL_950) res = LAD_BOTH;
                else if (level < LVL_1540) res = LAD_SW2;
                else res = LAD_SW1;
            end
            LAD_SW2:
            begin
                if (level > LVL_1700) res = LAD_NONE;
                else if (level < LVL_600) res = LAD_SW1;
                else if (level < LVL_950) res = LAD_BOTH;
                else res = LAD_SW2;
            end
            default:
            begin
                if (level > LVL_2600) res = LAD_NONE;
                else if (level > LVL_1500) res = LAD_SW1;
                else if (level > LVL_988) res = LAD_SW2;
                else res = LAD_BOTH;
            end
        endcase
        return res;
    endfunction

endpackage

/* sv/lbpc_front.sv */
// Front part: averages the samples, decodes the ladder, debounces and classifies presses.
module lbpc_front
    import lbpc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [SAMPLE_W-1:0]         sample_a,
    input  logic [SAMPLE_W-1:0]         sample_b,
    input  logic [SAMPLE_W-1:0]         sample_c,
    input  logic [SAMPLE_W-1:0]         sample_d,
    input  logic [TICK_W-1:0]           now_ticks,
    input  logic signed [DELTA_W-1:0]   encoder_delta,
    input  logic                        cfg_wr,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    output logic                        push,
    output poll_events_t                push_data,
    input  logic                        queue_full
);

    logic [SAMPLE_W-1:0] samples [4];
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] avg;

    logic s1_valid_reg, s1_valid_next;
    logic [SAMPLE_W-1:0] s1_level_reg;
    logic [TICK_W-1:0] s1_now_reg;
    logic signed [DELTA_W-1:0] s1_delta_reg;

    logic [CFG_W-1:0] debounce_reg, debounce_next;
    logic [CFG_W-1:0] long_press_reg, long_press_next;
    ladder_t ladder_reg, ladder_next;
    logic [TICK_W-1:0] last_change_reg, last_change_next;
    logic [TICK_W-1:0] ok_press_reg, ok_press_next;
    logic [TICK_W-1:0] back_press_reg, back_press_next;

    logic in_accept;
    logic advance;
    ladder_t decoded;
    logic changed;
    logic ok_long;
    logic back_long;
    logic have_btn;
    kind_t btn_kind;

    assign samples[0] = sample_a;
    assign samples[1] = sample_b;
    assign samples[2] = sample_c;
    assign samples[3] = sample_d;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < SAMPLES_PER_POLL; i++)
        begin
            sum = sum + SUM_W'(samples[i % 4]);
        end
        avg = sum / SUM_W'(SAMPLES_PER_POLL);
    end

    assign in_stall = s1_valid_reg && queue_full;
    assign in_accept = in_valid && !in_stall;
    assign advance = s1_valid_reg && !queue_full;

    assign decoded = decode_ladder(ladder_reg, s1_level_reg);
    assign changed = (decoded != ladder_reg)
        && ((s1_now_reg - last_change_reg) >= TICK_W'(debounce_reg));
    assign ok_long = (s1_now_reg - ok_press_reg) >= TICK_W'(long_press_reg);
    assign back_long = (s1_now_reg - back_press_reg) >= TICK_W'(long_press_reg);

    always_comb
    begin
        ladder_next = ladder_reg;
        last_change_next = last_change_reg;
        ok_press_next = ok_press_reg;
        back_press_next = back_press_reg;
        have_btn = 1'b0;
        btn_kind = KIND_OK_SHORT;
        if (advance && changed)
        begin
            ladder_next = decoded;
            last_change_next = s1_now_reg;
            if (ladder_reg == LAD_BOTH)
            begin
                if (decoded == LAD_SW1) ok_press_next = s1_now_reg;
                else if (decoded == LAD_SW2) back_press_next = s1_now_reg;
            end
            else if (decoded == LAD_BOTH)
            begin
                if (ladder_reg != LAD_SW1) ok_press_next = s1_now_reg;
                if (ladder_reg != LAD_SW2) back_press_next = s1_now_reg;
            end
            else if (ladder_reg == LAD_SW1)
            begin
                have_btn = 1'b1;
                btn_kind = ok_long ? KIND_OK_LONG : KIND_OK_SHORT;
                if (decoded == LAD_SW2) back_press_next = s1_now_reg;
            end
            else if (ladder_reg == LAD_SW2)
            begin
                have_btn = 1'b1;
                btn_kind = back_long ? KIND_BACK_LONG : KIND_BACK_SHORT;
                if (decoded == LAD_SW1) ok_press_next = s1_now_reg;
            end
            else
            begin
                if (decoded == LAD_SW1) ok_press_next = s1_now_reg;
                else back_press_next = s1_now_reg;
            end
        end
    end

    always_comb
    begin
        push_data.enc_valid = (s1_delta_reg != '0);
        push_data.delta = s1_delta_reg;
        push_data.btn_valid = have_btn;
        push_data.btn_kind = btn_kind;
        push = advance && ((s1_delta_reg != '0) || have_btn);
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept) s1_valid_next = 1'b1;
        else if (advance) s1_valid_next = 1'b0;
    end

    always_comb
    begin
        debounce_next = debounce_reg;
        long_press_next = long_press_reg;
        if (cfg_wr && (cfg_index == CFG_DEBOUNCE)) debounce_next = cfg_data;
        if (cfg_wr && (cfg_index == CFG_LONG_PRESS)) long_press_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            debounce_reg <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            ladder_reg <= LAD_NONE;
            last_change_reg <= '0;
            ok_press_reg <= '0;
            back_press_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            debounce_reg <= debounce_next;
            long_press_reg <= long_press_next;
            ladder_reg <= ladder_next;
            last_change_reg <= last_change_next;
            ok_press_reg <= ok_press_next;
            back_press_reg <= back_press_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_level_reg <= avg[SAMPLE_W-1:0];
            s1_now_reg <= now_ticks;
            s1_delta_reg <= encoder_delta;
        end
    end

endmodule

/* sv/lbpc_queue.sv */
// Short queue of per-poll event pairs between the front and back parts.
module lbpc_queue
    import lbpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  poll_events_t push_data,
    output logic         full,
    input  logic         pop,
    output poll_events_t pop_data,
    output logic         empty
);

    poll_events_t mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_ptr_reg] <= push_data;
    end

endmodule

/* sv/lbpc_back.sv */
// Back part: emits the encoder and button events of one poll, one item per cycle while out_stall is low.
module lbpc_back
    import lbpc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       queue_empty,
    input  poll_events_t               queue_data,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 event_kind,
    output logic signed [DELTA_W-1:0]  event_delta,
    output logic                       last_of_poll
);

    logic cur_enc_reg, cur_enc_next;
    logic cur_btn_reg, cur_btn_next;
    logic signed [DELTA_W-1:0] cur_delta_reg;
    kind_t cur_kind_reg;

    logic pending;
    logic out_accept;
    logic last_emit;
    logic load;

    assign pending = cur_enc_reg || cur_btn_reg;
    assign out_valid = pending;
    assign out_accept = pending && !out_stall;
    assign last_emit = out_accept && (!cur_enc_reg || !cur_btn_reg);
    assign load = !pending || last_emit;
    assign pop = load && !queue_empty;

    assign event_kind = cur_enc_reg ? KIND_ENC : cur_kind_reg;
    assign event_delta = cur_enc_reg ? cur_delta_reg : '0;
    assign last_of_poll = cur_enc_reg ? !cur_btn_reg : 1'b1;

    always_comb
    begin
        cur_enc_next = cur_enc_reg;
        cur_btn_next = cur_btn_reg;
        if (pop)
        begin
            cur_enc_next = queue_data.enc_valid;
            cur_btn_next = queue_data.btn_valid;
        end
        else if (out_accept)
        begin
            if (cur_enc_reg) cur_enc_next = 1'b0;
            else cur_btn_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_enc_reg <= 1'b0;
            cur_btn_reg <= 1'b0;
        end
        else
        begin
            cur_enc_reg <= cur_enc_next;
            cur_btn_reg <= cur_btn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_delta_reg <= queue_data.delta;
            cur_kind_reg <= queue_data.btn_kind;
        end
    end

endmodule

/* sv/ladder_button_press_classifier_top.sv */
// Top level of the resistor ladder button press classifier.
//
//   channel   direction  handshake             payload
//   in        in         in_valid / in_stall   sample_a..sample_d, now_ticks, encoder_delta
//   out       out        out_valid / out_stall event_kind, event_delta, last_of_poll
//   cfg       in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A poll is averaged on entry to the stage registers and classified, updating the ladder, on exit.
// The front takes one poll per cycle while the two-entry event queue has room.
// The back emits one event per cycle while out_stall is low, so a poll with both an encoder
// and a button event needs two output events; that output rate sets the sustained throughput.
// Reset is asynchronous and active low; it restores the register defaults and clears the ladder.
// Configuration writes are always accepted.
module ladder_button_press_classifier_top
    import lbpc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [SAMPLE_W-1:0]        sample_a,
    input  logic [SAMPLE_W-1:0]        sample_b,
    input  logic [SAMPLE_W-1:0]        sample_c,
    input  logic [SAMPLE_W-1:0]        sample_d,
    input  logic [TICK_W-1:0]          now_ticks,
    input  logic signed [DELTA_W-1:0]  encoder_delta,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 event_kind,
    output logic signed [DELTA_W-1:0]  event_delta,
    output logic                       last_of_poll,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    logic push;
    poll_events_t push_data;
    logic queue_full;
    logic pop;
    poll_events_t pop_data;
    logic queue_empty;

    assign cfg_ready = 1'b1;

    lbpc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_a      (sample_a),
        .sample_b      (sample_b),
        .sample_c      (sample_c),
        .sample_d      (sample_d),
        .now_ticks     (now_ticks),
        .encoder_delta (encoder_delta),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .push_data     (push_data),
        .queue_full    (queue_full)
    );

    lbpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    lbpc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .queue_data   (pop_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .event_delta  (event_delta),
        .last_of_poll (last_of_poll)
    );

endmodule

/* tb/ladder_button_press_classifier_top_tb.sv */
// Self-checking testbench for the resistor ladder button press classifier top level.
module ladder_button_press_classifier_top_tb;
    import lbpc_pkg::*;

    localparam int UNTYPED = -1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DIRECTED_ROWS = 24;

    typedef struct {
        logic [SAMPLE_W-1:0]       sa;
        logic [SAMPLE_W-1:0]       sb;
        logic [SAMPLE_W-1:0]       sc;
        logic [SAMPLE_W-1:0]       sd;
        logic [TICK_W-1:0]         now;
        logic signed [DELTA_W-1:0] delta;
    } poll_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [DELTA_W-1:0] delta;
        logic                      last;
    } press_event_t;

    typedef struct {
        poll_t                     poll;
        int                        n_typed;
        kind_t                     k0;
        logic signed [DELTA_W-1:0] d0;
        kind_t                     k1;
    } directed_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [SAMPLE_W-1:0]       sample_a;
    logic [SAMPLE_W-1:0]       sample_b;
    logic [SAMPLE_W-1:0]       sample_c;
    logic [SAMPLE_W-1:0]       sample_d;
    logic [TICK_W-1:0]         now_ticks;
    logic signed [DELTA_W-1:0] encoder_delta;
    logic                      out_valid;
    logic                      out_stall;
    logic [2:0]                event_kind;
    logic signed [DELTA_W-1:0] event_delta;
    logic                      last_of_poll;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;

    press_event_t pending_events[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    bit           pressure_go = 1'b0;

    ladder_t          held_state;
    logic [TICK_W-1:0] last_change_at;
    logic [TICK_W-1:0] ok_down_at;
    logic [TICK_W-1:0] back_down_at;
    logic [CFG_W-1:0]  debounce_cfg;
    logic [CFG_W-1:0]  long_cfg;

    logic [TICK_W-1:0] tick_cursor;
    int                ladder_zone;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'd5, 16'sd0}, 0,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd0, 12'd0, 12'd0, 12'd0, 32'd10, 16'sd32767}, 1,
          KIND_ENC, 16'sd32767, KIND_ENC},
        '{'{12'd0, 12'd0, 12'd0, 12'd0, 32'd100, 16'h8000}, 1,
          KIND_ENC, 16'h8000, KIND_ENC},
        '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'd110, 16'sd0}, 0,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'd130, 16'sd5}, 2,
          KIND_ENC, 16'sd5, KIND_OK_SHORT},
        '{'{12'd1200, 12'd1200, 12'd1200, 12'd1200, 32'd200, 16'sd0}, 0,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd2000, 12'd2000, 12'd2000, 12'd2000, 32'd800, 16'hFFFF}, 2,
          KIND_ENC, 16'hFFFF, KIND_BACK_LONG},
        '{'{12'd700, 12'd700, 12'd700, 12'd700, 32'd900, 16'sd0}, 0,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd1600, 12'd1600, 12'd1600, 12'd1600, 32'd1000, 16'sd3}, 1,
          KIND_ENC, 16'sd3, KIND_ENC},
        '{'{12'd1200, 12'd1200, 12'd1200, 12'd1200, 32'd1600, 16'sd0}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd500, 12'd500, 12'd500, 12'd500, 32'd1700, 16'sd0}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd800, 12'd800, 12'd800, 12'd800, 32'd1750, 16'sd0}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd1000, 12'd1000, 12'd1000, 12'd1000, 32'd1800, 16'sd0}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd800, 12'd800, 12'd800, 12'd800, 32'd1900, 16'sd0}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd3000, 12'd3000, 12'd3000, 12'd3000, 32'd2000, 16'sd0}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd600, 12'd600, 12'd600, 12'd599, 32'd2100, 16'sd0}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd2600, 12'd2600, 12'd2600, 12'd2600, 32'd2200, 16'sd0}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd4095, 12'd0, 12'd4095, 12'd0, 32'd2250, 16'sd0}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd2601, 12'd2601, 12'd2601, 12'd2601, 32'd2300, 16'sd1}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd0, 12'd0, 12'd0, 12'd0, 32'hFFFF_FF00, 16'sd0}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'h0000_0100, 16'hFFF9}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd1500, 12'd1500, 12'd1500, 12'd1500, 32'h0000_0200, 16'sd0}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd1700, 12'd1700, 12'd1700, 12'd1700, 32'h0000_0300, 16'sd0}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC},
        '{'{12'd1701, 12'd1701, 12'd1701, 12'd1702, 32'h0000_0400, 16'sd0}, UNTYPED,
          KIND_ENC, 16'sd0, KIND_ENC}
    };

    ladder_button_press_classifier_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_a      (sample_a),
        .sample_b      (sample_b),
        .sample_c      (sample_c),
        .sample_d      (sample_d),
        .now_ticks     (now_ticks),
        .encoder_delta (encoder_delta),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_kind    (event_kind),
        .event_delta   (event_delta),
        .last_of_poll  (last_of_poll),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic ladder_t classify_level(input ladder_t held, input int level);
        ladder_t res;
        res = held;
        case (held)
            LAD_NONE:
            begin
                if (level < 600) res = LAD_SW1;
                else if (level < 950) res = LAD_BOTH;
                else if (level < 1540) res = LAD_SW2;
                else if (level < 2600) res = LAD_SW1;
                else res = LAD_NONE;
            end
            LAD_SW1:
            begin
                if (level > 2600) res = LAD_NONE;
                else if (level < 950) res = LAD_BOTH;
                else if (level < 1540) res = LAD_SW2;
                else res = LAD_SW1;
            end
            LAD_SW2:
            begin
                if (level > 1700) res = LAD_NONE;
                else if (level < 600) res = LAD_SW1;
                else if (level < 950) res = LAD_BOTH;
                else res = LAD_SW2;
            end
            default:
            begin
                if (level > 2600) res = LAD_NONE;
                else if (level > 1500) res = LAD_SW1;
                else if (level > 988) res = LAD_SW2;
                else res = LAD_BOTH;
            end
        endcase
        return res;
    endfunction

    function automatic int classify_poll(input poll_t p, output press_event_t e0,
                                         output press_event_t e1);
        logic [SAMPLE_W-1:0] smp [4];
        int                  sum;
        int                  level;
        int                  n;
        ladder_t             old;
        ladder_t             nxt;
        logic [TICK_W-1:0]   since_change;
        bit                  have_btn;
        kind_t               btn_kind;
        smp[0] = p.sa;
        smp[1] = p.sb;
        smp[2] = p.sc;
        smp[3] = p.sd;
        sum = 0;
        for (int i = 0; i < SAMPLES_PER_POLL; i++) sum += int'(smp[i % 4]);
        level = sum / SAMPLES_PER_POLL;
        old = held_state;
        nxt = classify_level(old, level);
        since_change = p.now - last_change_at;
        have_btn = 1'b0;
        btn_kind = KIND_ENC;
        if (nxt != old && since_change >= TICK_W'(debounce_cfg)) begin
            if (old == LAD_BOTH) begin
                if (nxt == LAD_SW1) ok_down_at = p.now;
                else if (nxt == LAD_SW2) back_down_at = p.now;
            end else if (nxt == LAD_BOTH) begin
                if (old != LAD_SW1) ok_down_at = p.now;
                if (old != LAD_SW2) back_down_at = p.now;
            end else if (old == LAD_SW1) begin
                have_btn = 1'b1;
                btn_kind = ((p.now - ok_down_at) >= TICK_W'(long_cfg)) ? KIND_OK_LONG
                                                                         : KIND_OK_SHORT;
                if (nxt == LAD_SW2) back_down_at = p.now;
            end else if (old == LAD_SW2) begin
                have_btn = 1'b1;
                btn_kind = ((p.now - back_down_at) >= TICK_W'(long_cfg)) ? KIND_BACK_LONG
                                                                           : KIND_BACK_SHORT;
                if (nxt == LAD_SW1) ok_down_at = p.now;
            end else begin
                if (nxt == LAD_SW1) ok_down_at = p.now;
                else back_down_at = p.now;
            end
            held_state = nxt;
            last_change_at = p.now;
        end
        n = 0;
        e0 = '{KIND_ENC, 16'sd0, 1'b1};
        e1 = '{KIND_ENC, 16'sd0, 1'b1};
        if (p.delta != 16'sd0) begin
            e0 = '{KIND_ENC, p.delta, ~have_btn};
            n = 1;
        end
        if (have_btn) begin
            if (n == 0) e0 = '{btn_kind, 16'sd0, 1'b1};
            else e1 = '{btn_kind, 16'sd0, 1'b1};
            n++;
        end
        return n;
    endfunction

    function automatic void queue_predicted(input int n, input press_event_t e0,
                                            input press_event_t e1);
        if (n > 0) pending_events.push_back(e0);
        if (n > 1) pending_events.push_back(e1);
    endfunction

    function automatic logic [SAMPLE_W-1:0] jitter_sample(input int level);
        int v;
        v = level + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return SAMPLE_W'(v);
    endfunction

    function automatic poll_t make_poll();
        poll_t p;
        int    lvl;
        int    pick;
        int    span;
        int    dv;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            p.sa = SAMPLE_W'($urandom());
            p.sb = SAMPLE_W'($urandom());
            p.sc = SAMPLE_W'($urandom());
            p.sd = SAMPLE_W'($urandom());
            tick_cursor = $urandom();
        end else begin
            if ($urandom_range(0, 9) < 3) ladder_zone = $urandom_range(0, 6);
            case (ladder_zone)
                0: lvl = $urandom_range(2601, 4095);
                1: lvl = $urandom_range(0, 599);
                2: lvl = $urandom_range(1540, 2599);
                3: lvl = $urandom_range(600, 949);
                4: lvl = $urandom_range(950, 1539);
                5: lvl = $urandom_range(1501, 1700);
                default: lvl = $urandom_range(0, 4095);
            endcase
            if ($urandom_range(0, 4) == 0) begin
                p.sa = SAMPLE_W'($urandom());
                p.sb = SAMPLE_W'($urandom());
                p.sc = SAMPLE_W'($urandom());
                p.sd = SAMPLE_W'($urandom());
            end else begin
                p.sa = jitter_sample(lvl);
                p.sb = jitter_sample(lvl);
                p.sc = jitter_sample(lvl);
                p.sd = jitter_sample(lvl);
            end
            pick = $urandom_range(0, 19);
            if (pick < 10) span = 2 * int'(debounce_cfg) + 4;
            else if (pick < 15) span = int'(long_cfg) + int'(long_cfg) / 4 + 4;
            else if (pick < 19) span = 3;
            else span = -1;
            if (span < 0) tick_cursor = $urandom();
            else tick_cursor = tick_cursor + TICK_W'($urandom_range(0, span));
        end
        p.now = tick_cursor;
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
            p.delta = 16'sd0;
        end else if (pick < 18) begin
            dv = int'($urandom_range(0, 16)) - 8;
            p.delta = DELTA_W'(dv);
        end else begin
            p.delta = DELTA_W'($urandom());
        end
        return p;
    endfunction

    task automatic offer_poll(input poll_t p);
        in_valid <= 1'b1;
        sample_a <= p.sa;
        sample_b <= p.sb;
        sample_c <= p.sc;
        sample_d <= p.sd;
        now_ticks <= p.now;
        encoder_delta <= p.delta;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        if (idx == CFG_DEBOUNCE) debounce_cfg = val;
        else if (idx == CFG_LONG_PRESS) long_cfg = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        while (pending_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_polls(input int count);
        int           burst_left;
        int           gap;
        int           n;
        poll_t        p;
        press_event_t e0;
        press_event_t e1;
        burst_left = $urandom_range(1, 16);
        for (int i = 0; i < count; i++) begin
            p = make_poll();
            offer_poll(p);
            n = classify_poll(p, e0, e1);
            queue_predicted(n, e0, e1);
            burst_left--;
            if (i == count - 1) begin
                in_valid <= 1'b0;
            end else if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] dbn, input logic [CFG_W-1:0] lp,
                             input int count);
        settle();
        write_reg(CFG_DEBOUNCE, dbn);
        write_reg(CFG_LONG_PRESS, lp);
        run_random_polls(count);
    endtask

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk) begin : check_events
        press_event_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event: event_kind %0d event_delta %0d", event_kind,
                       event_delta);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                if (event_kind !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
                    fail_count++;
                end
                if (event_delta !== want.delta) begin
                    $error("event_delta: expected %0d, got %0d", want.delta, event_delta);
                    fail_count++;
                end
                if (last_of_poll !== want.last) begin
                    $error("last_of_poll: expected %0d, got %0d", want.last, last_of_poll);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stall_pattern
        int mode;
        int seg_left;
        int hold_left;
        bit pressure_done;
        out_stall = 1'b0;
        mode = 0;
        seg_left = 0;
        hold_left = 0;
        pressure_done = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (pressure_go && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(4, 40);
                end
                seg_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ~out_stall;
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int           n;
        press_event_t e0;
        press_event_t e1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_a = '0;
        sample_b = '0;
        sample_c = '0;
        sample_d = '0;
        now_ticks = '0;
        encoder_delta = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        held_state = LAD_NONE;
        last_change_at = '0;
        ok_down_at = '0;
        back_down_at = '0;
        debounce_cfg = DEBOUNCE_RESET;
        long_cfg = LONG_PRESS_RESET;
        tick_cursor = '0;
        ladder_zone = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            offer_poll(directed_rows[i].poll);
            n = classify_poll(directed_rows[i].poll, e0, e1);
            if (directed_rows[i].n_typed == UNTYPED) begin
                queue_predicted(n, e0, e1);
            end else if (directed_rows[i].n_typed == 1) begin
                pending_events.push_back('{directed_rows[i].k0, directed_rows[i].d0, 1'b1});
            end else if (directed_rows[i].n_typed == 2) begin
                pending_events.push_back('{directed_rows[i].k0, directed_rows[i].d0, 1'b0});
                pending_events.push_back('{directed_rows[i].k1, 16'sd0, 1'b1});
            end
        end
        tick_cursor = last_change_at;

        pressure_go = 1'b1;
        run_random_polls(90);
        run_phase(16'd0, 16'd0, 90);
        run_phase(16'hFFFF, 16'hFFFF, 90);
        run_phase(CFG_W'($urandom_range(0, 60)), CFG_W'($urandom_range(0, 800)), 90);
        run_phase(16'hFFFF, 16'd0, 90);
        run_phase(DEBOUNCE_RESET, LONG_PRESS_RESET, 90);

        while (pending_events.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
sv/lbpc_pkg.sv
sv/lbpc_front.sv
sv/lbpc_queue.sv
sv/lbpc_back.sv
sv/ladder_button_press_classifier_top.sv
tb/ladder_button_press_classifier_top_tb.sv
